// ===== rtl/smp_pkg.sv =====
// Package for the multichannel servo PWM sequencer: field widths, op codes,
// register indexes, reset values and the controller/datapath command and status.
// No dependencies.
package smp_pkg;

  // Default sizing of the sequencer
  localparam int unsigned CHANNELS_DEF   = 8;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed port field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned PINS_W    = 8;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned CHCOUNT_W = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  // Register reset values
  localparam logic [PERIOD_W-1:0]  PERIOD_TOP_RST    = 16'd39999;
  localparam logic [CHCOUNT_W-1:0] CHANNEL_COUNT_RST = 4'd1;

  // Request op codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_SET_DUTY = 2'd1,
    OP_ATTACH   = 2'd2,
    OP_START    = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_TOP    = 1'd0,
    REG_CHANNEL_COUNT = 1'd1
  } reg_idx_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic exec_op;     // apply a tick, set duty or attach request
    logic load_out;    // capture the result into the output register
    logic start_init;  // begin a layout: clear sum and sweep index
    logic sum_step;    // add one slot width
    logic div_init;    // load the divider with the spare ticks
    logic div_step;    // one quotient bit
    logic place_step;  // place one slot start
    logic fail;        // slots overflow: stop, flag error
    logic succeed;     // layout done: run
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic k_last;      // sweep index is on the last used channel
    logic div_last;    // last division step
    logic overflow;    // slot widths exceed the period
  } dp_status_t;

endpackage

// ===== rtl/sequential_multichannel_pwm.sv =====
// Top level of the multichannel servo PWM sequencer.
// Instantiates smp_ctrl and smp_datapath; depends on smp_pkg.
//
// One request in, one result out. Tick, set duty and attach requests can arrive
// back to back; the result appears in the output register on the next cycle.
// A start request runs the slot layout on a shared width read port and a
// one-bit-per-cycle divider: it sums the n used slot widths, checks them
// against the period, then (when the slots fit) divides the spare ticks with an
// LW-bit divider and places the slot starts, and finally presents the result.
// n is the used channel count and LW = max(COUNT_BITS+1, 16+clog2(CHANNELS+1)).
// An overflowing layout skips the division and placement and presents the error
// flag. New requests are stalled while a layout runs or while the output
// register holds an untaken result.
module sequential_multichannel_pwm #(
  parameter int unsigned CHANNELS   = smp_pkg::CHANNELS_DEF,
  parameter int unsigned COUNT_BITS = smp_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smp_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [smp_pkg::OP_W-1:0]       op_i,
  input  logic [smp_pkg::CH_W-1:0]       channel_i,
  input  logic [smp_pkg::VAL_W-1:0]      value_i,
  input  logic [smp_pkg::VAL_W-1:0]      low_limit_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [smp_pkg::PINS_W-1:0]     pins_o,
  output logic [smp_pkg::CH_W-1:0]       active_channel_o,
  output logic [smp_pkg::COUNT_W-1:0]    count_o,
  output logic                           layout_error_o
);
  import smp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // Sequencing of requests and layout steps
  smp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Counter, channel tables, layout arithmetic and output register
  smp_datapath #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (op_i),
    .channel_i        (channel_i),
    .value_i          (value_i),
    .low_limit_i      (low_limit_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pins_o           (pins_o),
    .active_channel_o (active_channel_o),
    .count_o          (count_o),
    .layout_error_o   (layout_error_o)
  );

endmodule

// ===== rtl/smp_ctrl.sv =====
// Controller for the multichannel servo PWM sequencer: request acceptance and
// the multi-cycle start layout sequence (sum, check, divide, place).
// Depends on smp_pkg.
module smp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [smp_pkg::OP_W-1:0]    op_i,
  input  smp_pkg::dp_status_t         sts_i,
  output logic                        in_stall_o,
  output smp_pkg::ctrl_cmd_t          cmd_o
);
  import smp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SUM   = 6'b000010,
    S_CHECK = 6'b000100,
    S_DIV   = 6'b001000,
    S_PLACE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (op_i == OP_START) begin
            cmd_o.start_init = 1'b1;
            state_d          = S_SUM;
          end else begin
            cmd_o.exec_op  = 1'b1;
            cmd_o.load_out = 1'b1;
          end
        end
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.k_last) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.overflow) begin
          cmd_o.fail = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_PLACE;
      end
      S_PLACE: begin
        cmd_o.place_step = 1'b1;
        if (sts_i.k_last) begin
          cmd_o.succeed = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A start request enters the width sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && !in_stall_o && op_i == OP_START)
      |=> state_q == S_SUM)
    else $error("start request did not begin layout");

  // Results are only loaded into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free)
    else $error("output register overwritten");

  // The divider runs until its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && !sts_i.div_last) |=> state_q == S_DIV)
    else $error("division cut short");

endmodule

// ===== rtl/smp_datapath.sv =====
// Datapath for the multichannel servo PWM sequencer: config registers, counter,
// per-channel slot tables, pulse state, layout sum/divide/place, output register.
// Depends on smp_pkg.
module smp_datapath #(
  parameter int unsigned CHANNELS   = smp_pkg::CHANNELS_DEF,
  parameter int unsigned COUNT_BITS = smp_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [smp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smp_pkg::CFG_DAT_W-1:0]  cfg_data_i,
  input  logic [smp_pkg::OP_W-1:0]       op_i,
  input  logic [smp_pkg::CH_W-1:0]       channel_i,
  input  logic [smp_pkg::VAL_W-1:0]      value_i,
  input  logic [smp_pkg::VAL_W-1:0]      low_limit_i,
  input  smp_pkg::ctrl_cmd_t             cmd_i,
  output smp_pkg::dp_status_t            sts_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [smp_pkg::PINS_W-1:0]     pins_o,
  output logic [smp_pkg::CH_W-1:0]       active_channel_o,
  output logic [smp_pkg::COUNT_W-1:0]    count_o,
  output logic                           layout_error_o
);
  import smp_pkg::*;

  localparam int unsigned CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IW  = CW + 1;
  localparam int unsigned NW  = $clog2(CHANNELS + 1);
  localparam int unsigned DVW = NW + 1;
  localparam int unsigned FW  = ((COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W) + 1;
  localparam int unsigned LW  = ((COUNT_BITS + 1) > (VAL_W + NW)) ?
                                (COUNT_BITS + 1) : (VAL_W + NW);
  localparam int unsigned DCW = $clog2(LW);
  localparam logic [LW-1:0] CMAX = LW'({COUNT_BITS{1'b1}});

  // Configuration
  logic [PERIOD_W-1:0]  period_top_q;
  logic [CHCOUNT_W-1:0] channel_count_q;

  // Channel tables
  logic [VAL_W-1:0]      slot_width_q [CHANNELS];
  logic [VAL_W-1:0]      duty_q       [CHANNELS];
  logic [COUNT_BITS-1:0] slot_start_q [CHANNELS];

  // Sequencer state
  logic [COUNT_BITS-1:0] tick_q, tick_d;
  logic [CW-1:0]         cur_q, cur_d;
  logic                  pulse_q, pulse_d;
  logic [COUNT_BITS-1:0] fall_q, fall_d;
  logic [CHANNELS-1:0]   pins_q, pins_d;
  logic                  running_q, running_d;
  logic                  error_q, error_d;

  // Layout state
  logic [CW-1:0]  k_q, k_d;
  logic [LW-1:0]  sum_q, sum_d;
  logic [LW-1:0]  pos_q, pos_d;
  logic [LW-1:0]  quo_q, quo_d;
  logic [DVW-1:0] rem_q, rem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [PINS_W-1:0]    out_pins_q;
  logic [CH_W-1:0]      out_ch_q;
  logic [COUNT_W-1:0]   out_count_q;
  logic                 out_err_q;

  // Combinational helpers
  logic [COUNT_BITS-1:0] top;
  logic [LW-1:0]         period;
  logic [NW-1:0]         used;
  logic [DVW-1:0]        divisor;
  logic                  sweep;
  logic [CW-1:0]         rd_idx;
  logic [VAL_W-1:0]      rd_width;
  logic [VAL_W-1:0]      duty_c;
  logic [COUNT_BITS-1:0] start_c;
  logic [VAL_W-1:0]      d_clamp;
  logic [FW-1:0]         fall_sum;
  logic [COUNT_BITS-1:0] fall_val;
  logic [IW-1:0]         adv_sum;
  logic [CW-1:0]         adv_idx;
  logic [COUNT_BITS-1:0] tick_nxt;
  logic [CHANNELS-1:0]   cur_bit;
  logic                  is_tick;
  logic                  ch_ok;
  logic [CW-1:0]         wr_idx;
  logic                  duty_we;
  logic                  width_we;
  logic [VAL_W-1:0]      duty_wdata;
  logic [VAL_W:0]        attach_sum;
  logic [DVW:0]          trial;
  logic                  trial_ge;
  logic [LW-1:0]         place_s;
  logic [COUNT_BITS-1:0] place_val;

  // Limits derived from configuration
  always_comb begin
    top    = COUNT_BITS'(period_top_q);
    period = LW'(top) + LW'(1);
    if (channel_count_q == '0) begin
      used = NW'(1);
    end else if (32'(channel_count_q) > CHANNELS) begin
      used = NW'(CHANNELS);
    end else begin
      used = NW'(channel_count_q);
    end
    divisor = DVW'(used) + DVW'(1);
  end

  // Table reads: one shared width port, swept by k during layout
  assign sweep    = cmd_i.sum_step | cmd_i.place_step;
  assign rd_idx   = sweep ? k_q : cur_q;
  assign rd_width = slot_width_q[rd_idx];
  assign duty_c   = duty_q[cur_q];
  assign start_c  = slot_start_q[cur_q];

  // Pulse geometry for the active channel
  always_comb begin
    d_clamp  = (duty_c > rd_width) ? rd_width : duty_c;
    fall_sum = FW'(start_c) + FW'(d_clamp);
    fall_val = (fall_sum > FW'(top)) ? top : COUNT_BITS'(fall_sum);
    adv_sum  = IW'(cur_q) + IW'(1);
    adv_idx  = (adv_sum >= IW'(used)) ? '0 : CW'(adv_sum);
    tick_nxt = (tick_q >= top) ? '0 : tick_q + COUNT_BITS'(1);
    cur_bit  = CHANNELS'(1) << cur_q;
  end

  // Table writes for set duty and attach
  always_comb begin
    is_tick    = cmd_i.exec_op && (op_i == OP_TICK);
    ch_ok      = (32'(channel_i) < CHANNELS);
    wr_idx     = CW'(channel_i);
    attach_sum = (VAL_W+1)'(value_i) + (VAL_W+1)'(low_limit_i);
    duty_we    = cmd_i.exec_op && ch_ok &&
                 ((op_i == OP_SET_DUTY) || (op_i == OP_ATTACH));
    width_we   = cmd_i.exec_op && ch_ok && (op_i == OP_ATTACH);
    duty_wdata = (op_i == OP_ATTACH) ? attach_sum[VAL_W:1] : value_i;
  end

  // Divider step and slot placement
  always_comb begin
    trial     = {rem_q, quo_q[LW-1]};
    trial_ge  = (trial >= {1'b0, divisor});
    place_s   = pos_q + quo_q;
    place_val = (place_s > CMAX) ? {COUNT_BITS{1'b1}} : COUNT_BITS'(place_s);
  end

  // Sequencer next state
  always_comb begin
    tick_d    = tick_q;
    cur_d     = cur_q;
    pulse_d   = pulse_q;
    fall_d    = fall_q;
    pins_d    = pins_q;
    running_d = running_q;
    error_d   = error_q;
    if (is_tick) begin
      tick_d = tick_nxt;
      if (running_q) begin
        if (!pulse_q) begin
          if (tick_nxt == start_c) begin
            if (d_clamp == '0) begin
              cur_d = adv_idx;
            end else begin
              fall_d  = fall_val;
              pulse_d = 1'b1;
              pins_d  = pins_q | cur_bit;
            end
          end
        end else if (tick_nxt == fall_q) begin
          pins_d  = pins_q & ~cur_bit;
          pulse_d = 1'b0;
          cur_d   = adv_idx;
        end
      end
    end
    if (cmd_i.fail || cmd_i.succeed) begin
      cur_d     = '0;
      pulse_d   = 1'b0;
      fall_d    = '0;
      pins_d    = '0;
      running_d = cmd_i.succeed;
      error_d   = cmd_i.fail;
    end
  end

  // Layout next state
  always_comb begin
    k_d    = k_q;
    sum_d  = sum_q;
    pos_d  = pos_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dcnt_d = dcnt_q;
    if (cmd_i.start_init) begin
      k_d   = '0;
      sum_d = '0;
    end
    if (cmd_i.sum_step) begin
      sum_d = sum_q + LW'(rd_width);
      k_d   = k_q + CW'(1);
    end
    if (cmd_i.div_init) begin
      quo_d  = period - sum_q;
      rem_d  = '0;
      dcnt_d = DCW'(LW - 1);
      k_d    = '0;
      pos_d  = '0;
    end
    if (cmd_i.div_step) begin
      rem_d  = trial_ge ? DVW'(trial - {1'b0, divisor}) : DVW'(trial);
      quo_d  = {quo_q[LW-2:0], trial_ge};
      dcnt_d = dcnt_q - DCW'(1);
    end
    if (cmd_i.place_step) begin
      pos_d = place_s + LW'(rd_width);
      k_d   = k_q + CW'(1);
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.out_free = !out_valid_q || !out_stall_i;
    sts_o.k_last   = ((IW'(k_q) + IW'(1)) == IW'(used));
    sts_o.div_last = (dcnt_q == '0);
    sts_o.overflow = (sum_q > period);
  end

  assign out_valid_d = cmd_i.load_out || (out_valid_q && out_stall_i);

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_top_q    <= PERIOD_TOP_RST;
      channel_count_q <= CHANNEL_COUNT_RST;
      tick_q          <= '0;
      cur_q           <= '0;
      pulse_q         <= 1'b0;
      fall_q          <= '0;
      pins_q          <= '0;
      running_q       <= 1'b0;
      error_q         <= 1'b0;
      out_valid_q     <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        slot_width_q[i] <= '0;
        duty_q[i]       <= '0;
        slot_start_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PERIOD_TOP:    period_top_q    <= PERIOD_W'(cfg_data_i);
          REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CHCOUNT_W-1:0];
          default: ;
        endcase
      end
      tick_q      <= tick_d;
      cur_q       <= cur_d;
      pulse_q     <= pulse_d;
      fall_q      <= fall_d;
      pins_q      <= pins_d;
      running_q   <= running_d;
      error_q     <= error_d;
      out_valid_q <= out_valid_d;
      if (duty_we)  duty_q[wr_idx]       <= duty_wdata;
      if (width_we) slot_width_q[wr_idx] <= value_i;
      if (cmd_i.place_step) slot_start_q[k_q] <= place_val;
    end
  end

  // Layout and result payload registers
  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    sum_q  <= sum_d;
    pos_q  <= pos_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dcnt_q <= dcnt_d;
    if (cmd_i.load_out) begin
      out_pins_q  <= PINS_W'(pins_d);
      out_ch_q    <= CH_W'(cur_d);
      out_count_q <= COUNT_W'(tick_d);
      out_err_q   <= error_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pins_o           = out_pins_q;
  assign active_channel_o = out_ch_q;
  assign count_o          = out_count_q;
  assign layout_error_o   = out_err_q;

  // Only the active channel can drive its pin
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(pins_q))
    else $error("more than one pin high");

  // A pin is high exactly while a pulse is in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_q == (pins_q != '0))
    else $error("pulse flag and pins disagree");

  // Stopped sequencer holds all pins low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (pins_q == '0))
    else $error("pin high while stopped");

  // A failed layout leaves the sequencer stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_q |-> !running_q)
    else $error("running with layout error");

endmodule
